[design/eed_pkg.sv]
`default_nettype none
package eed_pkg;

   // character codes
   localparam logic [15:0] CH_BSLASH = 16'h005C;
   localparam logic [15:0] CH_ZERO   = 16'h0030;
   localparam logic [15:0] CH_SEVEN  = 16'h0037;
   localparam logic [15:0] CH_NINE   = 16'h0039;
   localparam logic [15:0] CH_LO_A   = 16'h0061;
   localparam logic [15:0] CH_LO_B   = 16'h0062;
   localparam logic [15:0] CH_LO_C   = 16'h0063;
   localparam logic [15:0] CH_LO_E   = 16'h0065;
   localparam logic [15:0] CH_LO_F   = 16'h0066;
   localparam logic [15:0] CH_LO_N   = 16'h006E;
   localparam logic [15:0] CH_LO_R   = 16'h0072;
   localparam logic [15:0] CH_LO_T   = 16'h0074;
   localparam logic [15:0] CH_LO_V   = 16'h0076;
   localparam logic [15:0] CH_LO_X   = 16'h0078;
   localparam logic [15:0] CH_UP_A   = 16'h0041;
   localparam logic [15:0] CH_UP_F   = 16'h0046;

   // control codes produced by the letter escapes
   localparam logic [15:0] CC_BEL = 16'd7;
   localparam logic [15:0] CC_BS  = 16'd8;
   localparam logic [15:0] CC_TAB = 16'd9;
   localparam logic [15:0] CC_LF  = 16'd10;
   localparam logic [15:0] CC_VT  = 16'd11;
   localparam logic [15:0] CC_FF  = 16'd12;
   localparam logic [15:0] CC_CR  = 16'd13;
   localparam logic [15:0] CC_ESC = 16'h001B;

   // parser modes
   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_ESC    = 3'd1;
   localparam logic [2:0] MODE_HEX0   = 3'd2;
   localparam logic [2:0] MODE_HEX1   = 3'd3;
   localparam logic [2:0] MODE_OCT0   = 3'd4;
   localparam logic [2:0] MODE_OCT    = 3'd5;
   localparam logic [2:0] MODE_STOP   = 3'd6;

   localparam int MAX_RES = 3;

   // one result beat
   typedef struct packed {
      logic [15:0] out_char;
      logic        has_char;
      logic        line_end;
   } res_type;

   // results decoded from one input beat
   typedef struct packed {
      logic [1:0]                 count;
      res_type [MAX_RES-1:0]      res;
   } dec_out_type;

endpackage
`default_nettype wire

[design/eed_decode.sv]
`default_nettype none
module eed_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [15:0]           in_char,
   input  wire logic                  in_last,
   input  wire logic                  advance,
   output eed_pkg::dec_out_type       dec_out
);

   typedef struct packed {
      logic [1:0]       cnt;
      logic [2:0][15:0] ch;
   } char_list_type;

   // append one character, at most three per beat
   function automatic char_list_type put_ch(char_list_type l, logic [15:0] c);
      char_list_type r;
      r = l;
      case (l.cnt)
         2'd0: begin r.ch[0] = c; r.cnt = 2'd1; end
         2'd1: begin r.ch[1] = c; r.cnt = 2'd2; end
         2'd2: begin r.ch[2] = c; r.cnt = 2'd3; end
         default: r = l;
      endcase
      return r;
   endfunction

   logic [2:0] mode_ff, mode_in;
   logic [8:0] nv_ff, nv_in;
   logic [1:0] dc_ff, dc_in;

   char_list_type lst;
   logic          hex_ok;
   logic [3:0]    hex_val;
   logic          oct_ok;
   logic          plain_esc;

   // digit classification
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = in_char[3:0];
      if (in_char >= eed_pkg::CH_ZERO && in_char <= eed_pkg::CH_NINE) begin
         hex_val = in_char[3:0];
      end else if ((in_char >= eed_pkg::CH_LO_A && in_char <= eed_pkg::CH_LO_F) ||
                   (in_char >= eed_pkg::CH_UP_A && in_char <= eed_pkg::CH_UP_F)) begin
         hex_val = in_char[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
      oct_ok    = (in_char >= eed_pkg::CH_ZERO) && (in_char <= eed_pkg::CH_SEVEN);
      plain_esc = (in_char == eed_pkg::CH_BSLASH) && !in_last;
   end

   // per-character decode and next state
   always_comb begin
      lst     = '0;
      mode_in = mode_ff;
      nv_in   = nv_ff;
      dc_in   = dc_ff;
      case (mode_ff)
         eed_pkg::MODE_ESC: begin
            mode_in = eed_pkg::MODE_NORMAL;
            case (in_char)
               eed_pkg::CH_LO_A:   lst = put_ch(lst, eed_pkg::CC_BEL);
               eed_pkg::CH_LO_B:   lst = put_ch(lst, eed_pkg::CC_BS);
               eed_pkg::CH_LO_C:   mode_in = eed_pkg::MODE_STOP;
               eed_pkg::CH_LO_E:   lst = put_ch(lst, eed_pkg::CC_ESC);
               eed_pkg::CH_LO_F:   lst = put_ch(lst, eed_pkg::CC_FF);
               eed_pkg::CH_LO_N:   lst = put_ch(lst, eed_pkg::CC_LF);
               eed_pkg::CH_LO_R:   lst = put_ch(lst, eed_pkg::CC_CR);
               eed_pkg::CH_LO_T:   lst = put_ch(lst, eed_pkg::CC_TAB);
               eed_pkg::CH_LO_V:   lst = put_ch(lst, eed_pkg::CC_VT);
               eed_pkg::CH_LO_X:   mode_in = eed_pkg::MODE_HEX0;
               eed_pkg::CH_BSLASH: lst = put_ch(lst, eed_pkg::CH_BSLASH);
               eed_pkg::CH_ZERO: begin
                  nv_in   = '0;
                  mode_in = eed_pkg::MODE_OCT0;
               end
               default: begin
                  if (oct_ok) begin
                     nv_in   = {6'd0, in_char[2:0]};
                     dc_in   = 2'd2;
                     mode_in = eed_pkg::MODE_OCT;
                  end else begin
                     lst = put_ch(lst, eed_pkg::CH_BSLASH);
                     lst = put_ch(lst, in_char);
                  end
               end
            endcase
         end
         eed_pkg::MODE_HEX0: begin
            if (hex_ok) begin
               nv_in   = {5'd0, hex_val};
               mode_in = eed_pkg::MODE_HEX1;
            end else begin
               mode_in = eed_pkg::MODE_NORMAL;
               lst = put_ch(lst, eed_pkg::CH_BSLASH);
               lst = put_ch(lst, eed_pkg::CH_LO_X);
               if (plain_esc) mode_in = eed_pkg::MODE_ESC;
               else lst = put_ch(lst, in_char);
            end
         end
         eed_pkg::MODE_HEX1: begin
            mode_in = eed_pkg::MODE_NORMAL;
            if (hex_ok) begin
               lst = put_ch(lst, {8'd0, nv_ff[3:0], hex_val});
            end else begin
               lst = put_ch(lst, {12'd0, nv_ff[3:0]});
               if (plain_esc) mode_in = eed_pkg::MODE_ESC;
               else lst = put_ch(lst, in_char);
            end
         end
         eed_pkg::MODE_OCT0: begin
            if (oct_ok) begin
               nv_in   = {6'd0, in_char[2:0]};
               dc_in   = 2'd2;
               mode_in = eed_pkg::MODE_OCT;
            end else begin
               mode_in = eed_pkg::MODE_NORMAL;
               lst = put_ch(lst, '0);
               if (plain_esc) mode_in = eed_pkg::MODE_ESC;
               else lst = put_ch(lst, in_char);
            end
         end
         eed_pkg::MODE_OCT: begin
            if (oct_ok) begin
               nv_in = {nv_ff[5:0], in_char[2:0]};
               if (dc_ff <= 2'd1) begin
                  mode_in = eed_pkg::MODE_NORMAL;
                  lst = put_ch(lst, {7'd0, nv_in});
               end else begin
                  dc_in = dc_ff - 2'd1;
               end
            end else begin
               mode_in = eed_pkg::MODE_NORMAL;
               lst = put_ch(lst, {7'd0, nv_ff});
               if (plain_esc) mode_in = eed_pkg::MODE_ESC;
               else lst = put_ch(lst, in_char);
            end
         end
         eed_pkg::MODE_STOP: begin
            mode_in = eed_pkg::MODE_STOP;
         end
         default: begin
            mode_in = eed_pkg::MODE_NORMAL;
            if (plain_esc) mode_in = eed_pkg::MODE_ESC;
            else lst = put_ch(lst, in_char);
         end
      endcase

      // flush a pending escape at line end, then return to reset state
      if (in_last) begin
         case (mode_in)
            eed_pkg::MODE_HEX0: begin
               lst = put_ch(lst, eed_pkg::CH_BSLASH);
               lst = put_ch(lst, eed_pkg::CH_LO_X);
            end
            eed_pkg::MODE_HEX1, eed_pkg::MODE_OCT: lst = put_ch(lst, {7'd0, nv_in});
            eed_pkg::MODE_OCT0: lst = put_ch(lst, '0);
            default: lst = lst;
         endcase
         mode_in = eed_pkg::MODE_NORMAL;
         nv_in   = '0;
         dc_in   = '0;
      end
   end

   // pack results, marking the line end or a bare marker
   always_comb begin
      dec_out.count = lst.cnt;
      for (int i = 0; i < eed_pkg::MAX_RES; i++) begin
         dec_out.res[i].out_char = lst.ch[i];
         dec_out.res[i].has_char = 1'b1;
         dec_out.res[i].line_end = in_last && (lst.cnt == 2'(i + 1));
      end
      if (in_last && lst.cnt == 2'd0) begin
         dec_out.count  = 2'd1;
         dec_out.res[0] = '{out_char: '0, has_char: 1'b0, line_end: 1'b1};
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= eed_pkg::MODE_NORMAL;
         nv_ff   <= '0;
         dc_ff   <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         nv_ff   <= nv_in;
         dc_ff   <= dc_in;
      end
   end

endmodule
`default_nettype wire

[design/eed_out_buf.sv]
`default_nettype none
module eed_out_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire eed_pkg::dec_out_type  dec_out,
   output logic                       can_load,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,   // out_char
   output logic                       rsp_tuser,   // has_char
   output logic                       rsp_tlast    // line_end
);

   eed_pkg::res_type [eed_pkg::MAX_RES-1:0] slot_ff, slot_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign can_load   = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   assign rsp_tdata = slot_ff[0].out_char;
   assign rsp_tuser = slot_ff[0].has_char;
   assign rsp_tlast = slot_ff[0].line_end;

   // load a new group or shift the next beat to the head
   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         slot_in = dec_out.res;
         cnt_in  = dec_out.count;
      end else if (pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule
`default_nettype wire

[design/echo_escape_decoder_top.sv]
`default_nettype none
// Echo-style backslash escape decoder. Each req beat carries one 16-bit
// character (tlast marks the last character of a line); each rsp beat carries
// one decoded character, tuser = 1 when the character is valid (0 only for the
// bare end-of-line marker of a line that produced no output) and tlast on the
// last result of the line. A character is registered on accept, decoded in one
// pass and its zero to three results go to a small output buffer that drains
// one result per beat. With one result per character and rsp_tready high the
// block sustains one character per cycle, held in the input register and then
// the output buffer; a character giving k results holds the buffer until all k
// drain, so input throughput is set by the output drain of one beat per cycle.
module echo_escape_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // in_char
   input  wire logic        req_tlast,   // line_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // out_char
   output logic             rsp_tuser,   // has_char
   output logic             rsp_tlast    // line_end
);

   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_char_ff;
   logic        in_last_ff;
   logic        can_load;
   logic        consume;
   logic        req_take;
   eed_pkg::dec_out_type dec_out;

   assign consume    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || can_load;
   assign req_take   = req_tvalid && req_tready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (consume) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   eed_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .in_char (in_char_ff),
      .in_last (in_last_ff),
      .advance (consume),
      .dec_out (dec_out)
   );

   eed_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (consume),
      .dec_out    (dec_out),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

[sim/echo_escape_decoder_top_tb.sv]
`timescale 1ns / 1ps
module echo_escape_decoder_top_tb;

   localparam int          HALF_PERIOD  = 4;
   localparam int          RESET_CYCLES = 8;
   localparam int          LIMIT_CYCLES = 200000;
   localparam int          HOLD_CYCLES  = 80;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          PHASE_CHARS  = 92;
   localparam int          NPROBE       = 23;

   // how a directed row is checked
   localparam logic [1:0]  CHECK_MODEL  = 2'd0;
   localparam logic [1:0]  EXPECT_NONE  = 2'd1;
   localparam logic [1:0]  EXPECT_ONE   = 2'd2;

   typedef struct packed {
      logic [15:0]      ch;
      logic             last;
      logic [1:0]       kind;
      eed_pkg::res_type res;
   } probe_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int unsigned send_idle_pct = 33;
   int unsigned recv_idle_pct = 69;
   bit          want_hold = 1'b0;
   int          mismatches = 0;
   int          cycle_count = 0;

   // decoder state mirror
   logic [2:0]  pmode = eed_pkg::MODE_NORMAL;
   logic [8:0]  pnum = '0;
   logic [1:0]  pdig = '0;

   // results of the character just decoded
   eed_pkg::res_type dec_res [eed_pkg::MAX_RES];
   int               dec_n;

   // decoded characters still to arrive, oldest first
   eed_pkg::res_type decoded_q [$];
   logic [15:0]      line_q [$];
   probe_row_type    probe_tab [NPROBE];

   echo_escape_decoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------- queue helpers ----------------

   // append a character to the tail of the line
   function automatic void add_line_char(logic [15:0] c);
      line_q.insert(line_q.size(), c);
   endfunction

   // append a result to the tail of the expected stream
   function automatic void add_expected(eed_pkg::res_type r);
      decoded_q.insert(decoded_q.size(), r);
   endfunction

   // ---------------- escape decoding predictor ----------------

   function automatic int hex_val(logic [15:0] c);
      if (c >= eed_pkg::CH_ZERO && c <= eed_pkg::CH_NINE)
         return int'(c - eed_pkg::CH_ZERO);
      if (c >= eed_pkg::CH_LO_A && c <= eed_pkg::CH_LO_F)
         return int'(c - eed_pkg::CH_LO_A) + 10;
      if (c >= eed_pkg::CH_UP_A && c <= eed_pkg::CH_UP_F)
         return int'(c - eed_pkg::CH_UP_A) + 10;
      return -1;
   endfunction

   function automatic bit is_octal(logic [15:0] c);
      return c >= eed_pkg::CH_ZERO && c <= eed_pkg::CH_SEVEN;
   endfunction

   // extra results beyond three are dropped
   function automatic void emit(logic [15:0] c);
      if (dec_n < eed_pkg::MAX_RES) begin
         dec_res[dec_n] = {c, 1'b1, 1'b0};
         dec_n++;
      end
   endfunction

   // ordinary character; a backslash opens an escape unless it ends the line
   function automatic void plain_char(logic [15:0] c, logic last);
      if (c == eed_pkg::CH_BSLASH && !last)
         pmode = eed_pkg::MODE_ESC;
      else
         emit(c);
   endfunction

   function automatic void escape_char(logic [15:0] c);
      pmode = eed_pkg::MODE_NORMAL;
      case (c)
         eed_pkg::CH_LO_A:   emit(eed_pkg::CC_BEL);
         eed_pkg::CH_LO_B:   emit(eed_pkg::CC_BS);
         eed_pkg::CH_LO_C:   pmode = eed_pkg::MODE_STOP;
         eed_pkg::CH_LO_E:   emit(eed_pkg::CC_ESC);
         eed_pkg::CH_LO_F:   emit(eed_pkg::CC_FF);
         eed_pkg::CH_LO_N:   emit(eed_pkg::CC_LF);
         eed_pkg::CH_LO_R:   emit(eed_pkg::CC_CR);
         eed_pkg::CH_LO_T:   emit(eed_pkg::CC_TAB);
         eed_pkg::CH_LO_V:   emit(eed_pkg::CC_VT);
         eed_pkg::CH_LO_X:   pmode = eed_pkg::MODE_HEX0;
         eed_pkg::CH_BSLASH: emit(eed_pkg::CH_BSLASH);
         eed_pkg::CH_ZERO: begin
            pnum  = '0;
            pmode = eed_pkg::MODE_OCT0;
         end
         default: begin
            if (c > eed_pkg::CH_ZERO && c <= eed_pkg::CH_SEVEN) begin
               pnum  = 9'(c[2:0]);
               pdig  = 2'd2;
               pmode = eed_pkg::MODE_OCT;
            end else begin
               emit(eed_pkg::CH_BSLASH);
               emit(c);
            end
         end
      endcase
   endfunction

   function automatic void decode_char(logic [15:0] c, logic last);
      int h;
      dec_n = 0;
      case (pmode)
         eed_pkg::MODE_ESC: escape_char(c);
         eed_pkg::MODE_HEX0: begin
            h = hex_val(c);
            if (h >= 0) begin
               pnum  = 9'(h);
               pmode = eed_pkg::MODE_HEX1;
            end else begin
               pmode = eed_pkg::MODE_NORMAL;
               emit(eed_pkg::CH_BSLASH);
               emit(eed_pkg::CH_LO_X);
               plain_char(c, last);
            end
         end
         eed_pkg::MODE_HEX1: begin
            h = hex_val(c);
            pmode = eed_pkg::MODE_NORMAL;
            if (h >= 0)
               emit(16'({pnum[3:0], 4'(h)}));
            else begin
               emit(16'(pnum[3:0]));
               plain_char(c, last);
            end
         end
         eed_pkg::MODE_OCT0: begin
            if (is_octal(c)) begin
               pnum  = 9'(c[2:0]);
               pdig  = 2'd2;
               pmode = eed_pkg::MODE_OCT;
            end else begin
               pmode = eed_pkg::MODE_NORMAL;
               emit(16'd0);
               plain_char(c, last);
            end
         end
         eed_pkg::MODE_OCT: begin
            if (is_octal(c)) begin
               pnum = {pnum[5:0], c[2:0]};
               if (pdig <= 2'd1) begin
                  pmode = eed_pkg::MODE_NORMAL;
                  emit(16'(pnum));
               end else
                  pdig = pdig - 2'd1;
            end else begin
               pmode = eed_pkg::MODE_NORMAL;
               emit(16'(pnum));
               plain_char(c, last);
            end
         end
         eed_pkg::MODE_STOP: ;
         default: begin
            pmode = eed_pkg::MODE_NORMAL;
            plain_char(c, last);
         end
      endcase

      // flush a pending number and close the line
      if (last) begin
         case (pmode)
            eed_pkg::MODE_HEX0: begin
               emit(eed_pkg::CH_BSLASH);
               emit(eed_pkg::CH_LO_X);
            end
            eed_pkg::MODE_HEX1, eed_pkg::MODE_OCT: emit(16'(pnum));
            eed_pkg::MODE_OCT0: emit(16'd0);
            default: ;
         endcase
         if (dec_n == 0) begin
            dec_res[0] = '0;
            dec_n = 1;
         end
         dec_res[dec_n-1].line_end = 1'b1;
         pmode = eed_pkg::MODE_NORMAL;
         pnum  = '0;
         pdig  = '0;
      end
   endfunction

   // ---------------- driving ----------------

   // offer one character, wait for the beat, then predict its results
   task automatic drive_char(logic [15:0] ch, logic last, bit use_model);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      decode_char(ch, last);
      if (use_model)
         for (int i = 0; i < dec_n; i++)
            add_expected(dec_res[i]);
   endtask

   function automatic probe_row_type row(logic [15:0] ch, logic last, logic [1:0] kind,
                                         logic [15:0] oc, logic has, logic le);
      return {ch, last, kind, oc, has, le};
   endfunction

   function automatic logic [15:0] rand_plain();
      case ($urandom_range(0, 3))
         0, 1:    return 16'($urandom_range(16'h0020, 16'h007E));
         2:       return 16'($urandom_range(0, 16'hFFFF));
         default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   function automatic logic [15:0] rand_hex_digit();
      case ($urandom_range(0, 2))
         0:       return eed_pkg::CH_ZERO + 16'($urandom_range(0, 9));
         1:       return eed_pkg::CH_LO_A + 16'($urandom_range(0, 5));
         default: return eed_pkg::CH_UP_A + 16'($urandom_range(0, 5));
      endcase
   endfunction

   function automatic logic [15:0] rand_letter();
      case ($urandom_range(0, 9))
         0:       return eed_pkg::CH_LO_A;
         1:       return eed_pkg::CH_LO_B;
         2:       return eed_pkg::CH_LO_C;
         3:       return eed_pkg::CH_LO_E;
         4:       return eed_pkg::CH_LO_F;
         5:       return eed_pkg::CH_LO_N;
         6:       return eed_pkg::CH_LO_R;
         7:       return eed_pkg::CH_LO_T;
         8:       return eed_pkg::CH_LO_V;
         default: return eed_pkg::CH_BSLASH;
      endcase
   endfunction

   // one piece of a line: plain text, a well-formed escape or a broken one
   function automatic void add_piece();
      int k;
      case ($urandom_range(0, 9))
         0, 1, 2: add_line_char(rand_plain());
         3, 4: begin
            add_line_char(eed_pkg::CH_BSLASH);
            add_line_char(rand_letter());
         end
         5: begin
            add_line_char(eed_pkg::CH_BSLASH);
            add_line_char(eed_pkg::CH_LO_X);
            k = $urandom_range(0, 3);
            repeat (k) add_line_char(rand_hex_digit());
         end
         6: begin
            add_line_char(eed_pkg::CH_BSLASH);
            add_line_char(eed_pkg::CH_ZERO);
            k = $urandom_range(0, 4);
            repeat (k) add_line_char(eed_pkg::CH_ZERO + 16'($urandom_range(0, 7)));
         end
         7: begin
            add_line_char(eed_pkg::CH_BSLASH);
            add_line_char(eed_pkg::CH_ZERO + 16'($urandom_range(1, 7)));
            k = $urandom_range(0, 3);
            repeat (k) add_line_char(eed_pkg::CH_ZERO + 16'($urandom_range(0, 7)));
         end
         8: begin
            add_line_char(eed_pkg::CH_BSLASH);
            add_line_char(16'($urandom_range(0, 16'hFFFF)));
         end
         default: add_line_char(rand_plain());
      endcase
   endfunction

   // random lines until about the given number of characters has gone in
   task automatic run_lines(int target);
      int sent;
      int pieces;
      sent = 0;
      while (sent < target) begin
         line_q.delete();
         pieces = $urandom_range(1, 5);
         repeat (pieces) add_piece();
         if ($urandom_range(0, 7) == 0)
            add_line_char(eed_pkg::CH_BSLASH);
         for (int i = 0; i < line_q.size(); i++)
            drive_char(line_q[i], i == line_q.size() - 1, 1'b1);
         sent += line_q.size();
      end
   endtask

   // ---------------- receiver ----------------

   // random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (reset)
            rsp_tready <= 1'b0;
         else if (want_hold) begin
            want_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // compare every result beat with the oldest pending expectation
   always @(posedge clock) begin : check_rsp
      eed_pkg::res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected beat, got char %h has %b end %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatches++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_tdata !== want.out_char) begin
               $display("%0t: out_char expected %h got %h", $time, want.out_char, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser !== want.has_char) begin
               $display("%0t: has_char expected %b got %b", $time, want.has_char, rsp_tuser);
               mismatches++;
            end
            if (rsp_tlast !== want.line_end) begin
               $display("%0t: line_end expected %b got %b", $time, want.line_end, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      // extremes, every number form, stop, line-end corner cases
      probe_tab[0]  = row(16'hFFFF, 1'b0, EXPECT_ONE, 16'hFFFF, 1'b1, 1'b0);
      probe_tab[1]  = row(16'h0000, 1'b1, EXPECT_ONE, 16'h0000, 1'b1, 1'b1);
      probe_tab[2]  = row(eed_pkg::CH_BSLASH, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[3]  = row(eed_pkg::CH_LO_E, 1'b0, EXPECT_ONE, eed_pkg::CC_ESC, 1'b1, 1'b0);
      probe_tab[4]  = row(eed_pkg::CH_BSLASH, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[5]  = row(eed_pkg::CH_LO_X, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[6]  = row(eed_pkg::CH_UP_F, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[7]  = row(eed_pkg::CH_LO_F, 1'b0, EXPECT_ONE, 16'h00FF, 1'b1, 1'b0);
      // hex escape with no digit
      probe_tab[8]  = row(eed_pkg::CH_BSLASH, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[9]  = row(eed_pkg::CH_LO_X, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[10] = row(16'h0067, 1'b0, CHECK_MODEL, '0, 1'b0, 1'b0);
      // largest octal value
      probe_tab[11] = row(eed_pkg::CH_BSLASH, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[12] = row(eed_pkg::CH_SEVEN, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[13] = row(eed_pkg::CH_SEVEN, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[14] = row(eed_pkg::CH_SEVEN, 1'b0, EXPECT_ONE, 16'h01FF, 1'b1, 1'b0);
      // pending number ended by a new escape, then stop until line end
      probe_tab[15] = row(eed_pkg::CH_BSLASH, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[16] = row(eed_pkg::CH_ZERO, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[17] = row(eed_pkg::CH_BSLASH, 1'b0, CHECK_MODEL, '0, 1'b0, 1'b0);
      probe_tab[18] = row(eed_pkg::CH_LO_C, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[19] = row(16'h005A, 1'b1, EXPECT_ONE, 16'h0000, 1'b0, 1'b1);
      // backslash as last character, bare hex escape at line end
      probe_tab[20] = row(eed_pkg::CH_BSLASH, 1'b1, EXPECT_ONE, eed_pkg::CH_BSLASH,
                          1'b1, 1'b1);
      probe_tab[21] = row(eed_pkg::CH_BSLASH, 1'b0, EXPECT_NONE, '0, 1'b0, 1'b0);
      probe_tab[22] = row(eed_pkg::CH_LO_X, 1'b1, CHECK_MODEL, '0, 1'b0, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles a third of the time, receiver two thirds
      send_idle_pct = 33;
      recv_idle_pct = 69;
      for (int i = 0; i < NPROBE; i++) begin
         drive_char(probe_tab[i].ch, probe_tab[i].last, probe_tab[i].kind == CHECK_MODEL);
         if (probe_tab[i].kind == EXPECT_ONE)
            add_expected(probe_tab[i].res);
      end
      run_lines(PHASE_CHARS);

      // phase two: roles swapped
      send_idle_pct = 69;
      recv_idle_pct = 33;
      run_lines(PHASE_CHARS);

      // phase three: full rate, with one long receiver hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      want_hold = 1'b1;
      run_lines(PHASE_CHARS);

      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
